// ===== src/lpcc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpcc_pkg
// Shared types and constants for the lidar point colouring block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcc_pkg;

  localparam logic [1:0] REQ_PIXEL  = 2'd0;
  localparam logic [1:0] REQ_POSE   = 2'd1;
  localparam logic [1:0] REQ_POINT  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
  localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] CFG_CENTER_X = 3'd2;
  localparam logic [2:0] CFG_CENTER_Y = 3'd3;
  localparam logic [2:0] CFG_WIDTH    = 3'd4;
  localparam logic [2:0] CFG_HEIGHT   = 3'd5;

  localparam logic [31:0] FOCAL_RST    = 32'd49449464;
  localparam logic [31:0] CENTER_X_RST = 32'd20938752;
  localparam logic [31:0] CENTER_Y_RST = 32'd15695872;
  localparam logic [10:0] WIDTH_RST    = 11'd640;
  localparam logic [9:0]  HEIGHT_RST   = 10'd480;

  localparam int POSE_COUNT = 12;
  localparam logic [7:0] WHITE = 8'd255;

  // One transaction as it travels down the pipeline.
  typedef struct packed {
    logic [1:0]         typ;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [18:0]        addr;
    logic [23:0]        rgb;
  } item_t;

endpackage

`default_nettype wire

// ===== src/lpcc_ram.sv =====
// ----------------------------------------------------------------------------
// lpcc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 524288
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire                       re,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/lpcc_div.sv =====
// ----------------------------------------------------------------------------
// lpcc_div
// Pipelined restoring divider producing a short quotient, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcc_div #(
  parameter int QB = 11
) (
  input  wire            clk,
  input  wire            adv,
  input  wire [63:0]     in_mag,
  input  wire [46:0]     in_den,
  input  wire            in_neg,
  input  wire            in_ok,
  output logic [QB-1:0]  out_q,
  output logic           out_ok
);

  logic [63:0]   rem_r [QB+1];
  logic [46:0]   den_r [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          neg_r [QB+1];
  logic          ok_r  [QB+1];

  // The first stage flags quotients too large for QB bits.
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= in_mag;
      den_r[0] <= in_den;
      q_r[0]   <= '0;
      neg_r[0] <= in_neg;
      ok_r[0]  <= in_ok && (in_mag < ({17'd0, in_den} << QB));
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [63:0] trial;
    assign trial = {17'd0, den_r[i]} << (QB - 1 - i);
    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[i+1] <= den_r[i];
        neg_r[i+1] <= neg_r[i];
        ok_r[i+1]  <= ok_r[i];
        if (rem_r[i] >= trial) begin
          rem_r[i+1]           <= rem_r[i] - trial;
          q_r[i+1]             <= q_r[i] | (QB'(1) << (QB - 1 - i));
        end else begin
          rem_r[i+1]           <= rem_r[i];
          q_r[i+1]             <= q_r[i];
        end
      end
    end
  end

  assign out_q  = q_r[QB];
  assign out_ok = ok_r[QB] && !(neg_r[QB] && (q_r[QB] != '0));

endmodule

`default_nettype wire

// ===== src/lidar_point_camera_colouring.sv =====
// ----------------------------------------------------------------------------
// lidar_point_camera_colouring
// Colours lidar points by pinhole projection into a stored camera frame.
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle while the pipeline is not held, and
// returns the result of a point transaction after the pose multiply stage, the
// saturating sum, the intrinsic multiplies, the sign fix-up, the bit-per-stage
// divider and the registered read of the frame store. Pixel writes travel down
// the same pipeline and are written to the frame store at the stage where points
// read it, so every point sees exactly the writes that were accepted before it.
// Pose writes take effect at acceptance; points sample the rotation entries at
// acceptance and the translation entries in the saturating-sum stage. The
// whole pipeline advances together; it holds only while a finished result
// waits to be taken. The frame store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_point_camera_colouring #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire [1:0]          in_req_type,
  input  wire [18:0]         in_pixel_addr,
  input  wire [23:0]         in_pixel_rgb,
  input  wire [3:0]          in_entry_index,
  input  wire signed [31:0]  in_entry_value,
  input  wire signed [31:0]  in_point_x,
  input  wire signed [31:0]  in_point_y,
  input  wire signed [31:0]  in_point_z,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               out_in_view,
  input  wire                cfg_we,
  input  wire [2:0]          cfg_index,
  input  wire [31:0]         cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int QB    = $clog2(MAXD) + 1;
  // Wide enough for both the quotient and the full image size registers.
  localparam int CW    = (QB + 1 > 12) ? QB + 1 : 12;

  // Configuration registers.
  logic [31:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [10:0] width_r;
  logic [9:0]  height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= lpcc_pkg::FOCAL_RST;
      focal_y_r  <= lpcc_pkg::FOCAL_RST;
      center_x_r <= lpcc_pkg::CENTER_X_RST;
      center_y_r <= lpcc_pkg::CENTER_Y_RST;
      width_r    <= lpcc_pkg::WIDTH_RST;
      height_r   <= lpcc_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpcc_pkg::CFG_FOCAL_X:  focal_x_r  <= cfg_data;
        lpcc_pkg::CFG_FOCAL_Y:  focal_y_r  <= cfg_data;
        lpcc_pkg::CFG_CENTER_X: center_x_r <= cfg_data;
        lpcc_pkg::CFG_CENTER_Y: center_y_r <= cfg_data;
        lpcc_pkg::CFG_WIDTH:    width_r    <= cfg_data[10:0];
        lpcc_pkg::CFG_HEIGHT:   height_r   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves whenever the output slot is free or being taken.
  logic adv;
  logic accept;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  // Pose matrix, written when a pose transaction is accepted.
  logic signed [31:0] pose_r [lpcc_pkg::POSE_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lpcc_pkg::POSE_COUNT; i++) begin
        pose_r[i] <= '0;
      end
    end else if (accept && in_req_type == lpcc_pkg::REQ_POSE &&
                 in_entry_index < 4'(lpcc_pkg::POSE_COUNT)) begin
      pose_r[in_entry_index] <= in_entry_value;
    end
  end

  lpcc_pkg::item_t in_item;
  assign in_item = '{typ: in_req_type, x: in_point_x, y: in_point_y, z: in_point_z,
                     addr: in_pixel_addr, rgb: in_pixel_rgb};

  // Stage 1: the nine pose products. Column one multiplies z; its sign is
  // flipped in the next stage.
  logic               v1_r;
  lpcc_pkg::item_t    item1_r;
  logic signed [63:0] prod1_r [3][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      item1_r <= in_item;
      for (int r = 0; r < 3; r++) begin
        prod1_r[r][0] <= pose_r[r*4+0] * in_point_x;
        prod1_r[r][1] <= pose_r[r*4+1] * in_point_z;
        prod1_r[r][2] <= pose_r[r*4+2] * in_point_y;
      end
    end
  end

  // Stage 2: floor each product to Q16.16, add the translation, saturate.
  logic               v2_r;
  lpcc_pkg::item_t    item2_r;
  logic signed [31:0] cam2_r [3];
  logic signed [31:0] cam_nxt [3];

  always_comb begin
    logic signed [63:0] negz;
    logic signed [49:0] sum;
    for (int r = 0; r < 3; r++) begin
      negz = -prod1_r[r][1];
      sum  = 50'(prod1_r[r][0] >>> 16) + 50'(negz >>> 16) +
             50'(prod1_r[r][2] >>> 16) + 50'(pose_r[r*4+3]);
      if (sum > 50'sd2147483647) begin
        cam_nxt[r] = 32'sh7FFFFFFF;
      end else if (sum < -50'sd2147483648) begin
        cam_nxt[r] = 32'sh80000000;
      end else begin
        cam_nxt[r] = sum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item2_r <= item1_r;
      for (int r = 0; r < 3; r++) begin
        cam2_r[r] <= cam_nxt[r];
      end
    end
  end

  // Stage 3: intrinsic products on the magnitudes of the camera x and y coordinates and on the depth.
  logic            v3_r;
  lpcc_pkg::item_t item3_r;
  logic [63:0]     t1x3_r, t2x3_r, t1y3_r, t2y3_r;
  logic            negx3_r, negy3_r, dpos3_r;
  logic [46:0]     den3_r;
  logic [31:0]     magx, magy, depth_u;

  assign magx    = cam2_r[0][31] ? 32'(-cam2_r[0]) : cam2_r[0];
  assign magy    = cam2_r[1][31] ? 32'(-cam2_r[1]) : cam2_r[1];
  assign depth_u = cam2_r[2];

  always_ff @(posedge clk) begin
    if (adv) begin
      item3_r <= item2_r;
      t1x3_r  <= focal_x_r * magx;
      t2x3_r  <= center_x_r * depth_u;
      t1y3_r  <= focal_y_r * magy;
      t2y3_r  <= center_y_r * depth_u;
      negx3_r <= cam2_r[0][31];
      negy3_r <= cam2_r[1][31];
      dpos3_r <= !cam2_r[2][31] && (cam2_r[2] != '0);
      den3_r  <= {cam2_r[2][30:0], 16'd0};
    end
  end

  // Stage 4: combine the two terms into a magnitude and a sign per axis.
  logic            v4_r;
  lpcc_pkg::item_t item4_r;
  logic [63:0]     magx4_r, magy4_r;
  logic            negx4_r, negy4_r, dpos4_r;
  logic [46:0]     den4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      item4_r <= item3_r;
      den4_r  <= den3_r;
      dpos4_r <= dpos3_r;
      if (!negx3_r) begin
        magx4_r <= t1x3_r + t2x3_r;
        negx4_r <= 1'b0;
      end else if (t2x3_r >= t1x3_r) begin
        magx4_r <= t2x3_r - t1x3_r;
        negx4_r <= 1'b0;
      end else begin
        magx4_r <= t1x3_r - t2x3_r;
        negx4_r <= 1'b1;
      end
      if (!negy3_r) begin
        magy4_r <= t1y3_r + t2y3_r;
        negy4_r <= 1'b0;
      end else if (t2y3_r >= t1y3_r) begin
        magy4_r <= t2y3_r - t1y3_r;
        negy4_r <= 1'b0;
      end else begin
        magy4_r <= t1y3_r - t2y3_r;
        negy4_r <= 1'b1;
      end
    end
  end

  // Divider lanes, one per axis, with the transaction delayed alongside.
  logic [QB-1:0] u_q, v_q;
  logic          u_ok, v_ok;

  lpcc_div #(.QB(QB)) u_div_u (
    .clk(clk), .adv(adv), .in_mag(magx4_r), .in_den(den4_r),
    .in_neg(negx4_r), .in_ok(dpos4_r), .out_q(u_q), .out_ok(u_ok)
  );

  lpcc_div #(.QB(QB)) u_div_v (
    .clk(clk), .adv(adv), .in_mag(magy4_r), .in_den(den4_r),
    .in_neg(negy4_r), .in_ok(dpos4_r), .out_q(v_q), .out_ok(v_ok)
  );

  logic            vd_r    [QB+1];
  lpcc_pkg::item_t itemd_r [QB+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      itemd_r[0] <= item4_r;
      for (int i = 0; i < QB; i++) begin
        itemd_r[i+1] <= itemd_r[i];
      end
    end
  end

  // Frame store stage: bounds check, pixel read for points, pixel write.
  lpcc_pkg::item_t itemd;
  logic [CW-1:0]   w_lim, h_lim;
  logic            view_nxt;
  logic [31:0]     rd_full, wr_full;
  logic            ram_we;
  logic [23:0]     ram_rdata;

  assign itemd    = itemd_r[QB];
  assign w_lim    = (CW'(width_r) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_r);
  assign h_lim    = (CW'(height_r) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(height_r);
  assign view_nxt = u_ok && v_ok && (CW'(u_q) < w_lim) && (CW'(v_q) < h_lim);
  assign rd_full  = 32'(v_q) * 32'(MAX_WIDTH) + 32'(u_q);
  assign wr_full  = 32'(itemd.addr);
  assign ram_we   = adv && vd_r[QB] && (itemd.typ == lpcc_pkg::REQ_PIXEL) &&
                    (wr_full < 32'(DEPTH));

  lpcc_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_frame (
    .clk(clk), .we(ram_we), .waddr(wr_full[AW-1:0]), .wdata(itemd.rgb),
    .re(adv), .raddr(rd_full[AW-1:0]), .rdata(ram_rdata)
  );

  // Output stage: aligned with the registered read data.
  logic            v6_r;
  lpcc_pkg::item_t item6_r;
  logic            view6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      item6_r <= itemd;
      view6_r <= view_nxt;
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v6_r <= 1'b0;
      for (int i = 0; i <= QB; i++) begin
        vd_r[i] <= 1'b0;
      end
    end else if (adv) begin
      v1_r    <= in_valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      vd_r[0] <= v4_r;
      for (int i = 0; i < QB; i++) begin
        vd_r[i+1] <= vd_r[i];
      end
      v6_r <= vd_r[QB];
    end
  end

  assign out_valid   = v6_r && (item6_r.typ == lpcc_pkg::REQ_POINT);
  assign out_x       = item6_r.x;
  assign out_y       = item6_r.y;
  assign out_z       = item6_r.z;
  assign out_in_view = view6_r;
  assign out_red     = view6_r ? ram_rdata[7:0]   : lpcc_pkg::WHITE;
  assign out_green   = view6_r ? ram_rdata[15:8]  : lpcc_pkg::WHITE;
  assign out_blue    = view6_r ? ram_rdata[23:16] : lpcc_pkg::WHITE;

endmodule

`default_nettype wire
